FILE: src/tprm_pkg.sv
// Package for the touchpad report to mouse report converter.
// Holds widths, register indexes, button and wheel codes and shared structs.
// No dependencies.
package tprm_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int REG_W = 12;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int STATUS_W = 8;
  localparam int COUNT_W = 8;
  localparam int DELTA_W = 13;
  localparam int WHEEL_W = 2;

  localparam logic [COUNT_W-1:0] MAX_POINTS = 8'd5;
  localparam logic [1:0] VALID_BITS = 2'b11;
  localparam logic [STATUS_W-1:0] BUTTON_ON = 8'd1;

  localparam logic [REG_W-1:0] MOVE_LIMIT_RST = 12'd400;
  localparam logic [REG_W-1:0] BUTTON_ZONE_TOP_RST = 12'd776;
  localparam logic [REG_W-1:0] X_LIMIT_RST = 12'd1500;
  localparam logic [REG_W-1:0] X_SPLIT_RST = 12'd750;
  localparam logic [REG_W-1:0] SCROLL_GAP_RST = 12'd80;

  localparam logic [1:0] HOLD_NONE = 2'b00;
  localparam logic [1:0] HOLD_LEFT = 2'b01;
  localparam logic [1:0] HOLD_RIGHT = 2'b10;

  localparam logic [WHEEL_W-1:0] WHEEL_NONE = 2'b00;
  localparam logic [WHEEL_W-1:0] WHEEL_UP = 2'b01;
  localparam logic [WHEEL_W-1:0] WHEEL_DOWN = 2'b11;

  typedef enum logic [2:0] {
    REG_MOVE_LIMIT = 3'd0,
    REG_BUTTON_ZONE_TOP = 3'd1,
    REG_X_LIMIT = 3'd2,
    REG_X_SPLIT = 3'd3,
    REG_SCROLL_GAP = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [REG_W-1:0] move_limit;
    logic [REG_W-1:0] button_zone_top;
    logic [REG_W-1:0] x_limit;
    logic [REG_W-1:0] x_split;
    logic [REG_W-1:0] scroll_gap;
  } cfg_t;

  typedef struct packed {
    logic       contact;
    logic       btn_hit;
    logic [1:0] btn_code;
    logic       scroll_cand;
    logic       no_report;
    logic       mot_valid;
    logic       mot_cur;
    logic       mot_in_zone;
  } ctrl_t;

endpackage

FILE: src/tprm_front.sv
// Front end: accepts touch reports and classifies them into queue entries.
// Depends on tprm_pkg; feeds tprm_queue.
module tprm_front
  import tprm_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [STATUS_W-1:0]    status_a,
  input  logic [COORD_WIDTH-1:0] point_a_x,
  input  logic [COORD_WIDTH-1:0] point_a_y,
  input  logic [STATUS_W-1:0]    status_b,
  input  logic [COORD_WIDTH-1:0] point_b_x,
  input  logic [COORD_WIDTH-1:0] point_b_y,
  input  logic [COUNT_W-1:0]     point_count,
  input  logic [STATUS_W-1:0]    button_state,
  input  cfg_t                   cfg,
  input  logic                   q_full,
  output logic                   push,
  output ctrl_t                  ctrl,
  output logic [COORD_WIDTH-1:0] mot_x,
  output logic [COORD_WIDTH-1:0] mot_y,
  output logic [COORD_WIDTH-1:0] a_y
);

  localparam int CMP_W = (COORD_WIDTH > REG_W) ? COORD_WIDTH : REG_W;

  logic                   a_zone;
  logic                   b_zone;
  logic                   two_plus;
  logic [COORD_WIDTH-1:0] btn_x;
  logic [COORD_WIDTH-1:0] gap;

  assign in_stall = q_full;
  assign push = in_valid && !q_full && (point_count <= MAX_POINTS);

  assign a_zone = CMP_W'(point_a_y) > CMP_W'(cfg.button_zone_top);
  assign b_zone = CMP_W'(point_b_y) > CMP_W'(cfg.button_zone_top);
  assign two_plus = point_count >= COUNT_W'(2);
  assign btn_x = a_zone ? point_a_x : point_b_x;
  assign gap = (point_a_y >= point_b_y) ? (point_a_y - point_b_y) : (point_b_y - point_a_y);

  always_comb begin
    ctrl.contact = (status_a[1:0] == VALID_BITS) && (point_count != '0);
    ctrl.btn_hit = a_zone || (two_plus && b_zone);
    if ((button_state == BUTTON_ON) && (CMP_W'(btn_x) <= CMP_W'(cfg.x_limit))) begin
      ctrl.btn_code = (CMP_W'(btn_x) < CMP_W'(cfg.x_split)) ? HOLD_LEFT : HOLD_RIGHT;
    end else begin
      ctrl.btn_code = HOLD_NONE;
    end
    ctrl.scroll_cand = (point_count == COUNT_W'(2)) &&
                       (CMP_W'(gap) < CMP_W'(cfg.scroll_gap));
    ctrl.no_report = !a_zone && !b_zone && two_plus;
    ctrl.mot_cur = a_zone && (point_count != COUNT_W'(1));
    ctrl.mot_valid = ctrl.mot_cur ? (status_b[1:0] == VALID_BITS)
                                  : (status_a[1:0] == VALID_BITS);
    ctrl.mot_in_zone = ctrl.mot_cur ? b_zone : a_zone;
  end

  assign mot_x = ctrl.mot_cur ? point_b_x : point_a_x;
  assign mot_y = ctrl.mot_cur ? point_b_y : point_a_y;
  assign a_y = point_a_y;

endmodule

FILE: src/tprm_queue.sv
// Short FIFO between the classifying front end and the executing back end.
// Depends on tprm_pkg for its default depth.
module tprm_queue
  import tprm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count exceeds depth");

endmodule

FILE: src/tprm_back.sv
// Back end: holds positions, flags and buttons and builds the mouse report.
// Depends on tprm_pkg; takes entries from tprm_queue.
module tprm_back
  import tprm_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       q_valid,
  input  ctrl_t                      ctrl,
  input  logic [COORD_WIDTH-1:0]     mot_x,
  input  logic [COORD_WIDTH-1:0]     mot_y,
  input  logic [COORD_WIDTH-1:0]     a_y,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DELTA_W-1:0]  delta_x,
  output logic signed [DELTA_W-1:0]  delta_y,
  output logic                       left_pressed,
  output logic                       right_pressed,
  output logic signed [WHEEL_W-1:0]  wheel_step
);

  localparam int CMP_W = (COORD_WIDTH > REG_W) ? COORD_WIDTH : REG_W;
  localparam int SW = CMP_W + 2;

  logic [COORD_WIDTH-1:0] last_x [2];
  logic [COORD_WIDTH-1:0] last_y [2];
  logic                   motion_restart;
  logic                   wheel_armed;
  logic [1:0]             held_buttons;

  logic [1:0]             held_next;
  logic signed [SW-1:0]   limit;
  logic signed [SW-1:0]   w;
  logic signed [SW-1:0]   mx;
  logic signed [SW-1:0]   my;
  logic                   w_ok;
  logic                   mx_ok;
  logic                   my_ok;
  logic                   scroll_take;
  logic                   emit;
  logic                   take_motion;
  logic                   store_pos;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic [WHEEL_W-1:0]     wheel;

  assign pop = q_valid && (!out_valid || !out_stall);

  assign limit = SW'(cfg.move_limit);
  assign w = SW'(a_y) - SW'(last_y[0]);
  assign mx = SW'(mot_x) - SW'(last_x[ctrl.mot_cur]);
  assign my = SW'(mot_y) - SW'(last_y[ctrl.mot_cur]);
  assign w_ok = (w <= limit) && (w >= -limit);
  assign mx_ok = (mx <= limit) && (mx >= -limit);
  assign my_ok = (my <= limit) && (my >= -limit);

  always_comb begin
    held_next = (ctrl.contact && ctrl.btn_hit) ? ctrl.btn_code : held_buttons;
    scroll_take = ctrl.contact && ctrl.scroll_cand && wheel_armed && w_ok;
    emit = !(ctrl.contact && !scroll_take && ctrl.no_report);
    store_pos = ctrl.contact && !scroll_take && !ctrl.no_report && ctrl.mot_valid;
    take_motion = store_pos && !motion_restart && !ctrl.mot_in_zone;
    dx = (take_motion && mx_ok) ? mx[DELTA_W-1:0] : '0;
    dy = (take_motion && my_ok) ? my[DELTA_W-1:0] : '0;
    if (!scroll_take || (w == '0)) begin
      wheel = WHEEL_NONE;
    end else if (!w[SW-1]) begin
      wheel = WHEEL_UP;
    end else begin
      wheel = WHEEL_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x[0] <= '0;
      last_x[1] <= '0;
      last_y[0] <= '0;
      last_y[1] <= '0;
      motion_restart <= 1'b0;
      wheel_armed <= 1'b0;
      held_buttons <= HOLD_NONE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= emit;
        held_buttons <= held_next;
        if (!ctrl.contact) begin
          motion_restart <= 1'b1;
        end else if (scroll_take) begin
          last_y[0] <= a_y;
          wheel_armed <= 1'b0;
        end else begin
          wheel_armed <= 1'b1;
          if (store_pos) begin
            last_x[ctrl.mot_cur] <= mot_x;
            last_y[ctrl.mot_cur] <= mot_y;
            motion_restart <= 1'b0;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      delta_x <= dx;
      delta_y <= dy;
      left_pressed <= held_next[0];
      right_pressed <= held_next[1];
      wheel_step <= wheel;
    end
  end

  a_wheel_no_motion: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (wheel_step != WHEEL_NONE)) |-> (delta_x == '0) && (delta_y == '0))
    else $error("scroll report carries motion");

  a_scroll_disarms: assert property (@(posedge clk) disable iff (rst)
    (pop && scroll_take) |=> !wheel_armed)
    else $error("wheel stays armed after a scroll step");

  a_one_button: assert property (@(posedge clk) disable iff (rst)
    $onehot0(held_buttons))
    else $error("both buttons held at once");

endmodule

FILE: src/touchpad_report_to_mouse_top.sv
// Top level of the touchpad report to mouse report converter.
// Holds the configuration registers; instantiates tprm_front, tprm_queue, tprm_back.
// Depends on tprm_pkg.
//
//   Channel  Direction  Handshake                    Beat
//   in       input      in_valid / in_stall          one two-point touch report
//   out      output     out_valid / out_stall        one mouse report
//   cfg      input      psel/penable/pwrite/pready   one register write or read
//
// One report is accepted per cycle while the queue is not full; its result is registered
// in the queue and then in tprm_back. The queue holds up to QUEUE_DEPTH entries, so the
// input keeps flowing for that many beats while out is stalled behind a waiting result.
// The registered loop on the stored positions and flags in tprm_back sets the rate.
// Reset is synchronous and active high; it restores register defaults and control state.
// Reports with a point count above five are accepted and dropped without a result.
module touchpad_report_to_mouse_top
  import tprm_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [STATUS_W-1:0]        status_a,
  input  logic [COORD_WIDTH-1:0]     point_a_x,
  input  logic [COORD_WIDTH-1:0]     point_a_y,
  input  logic [STATUS_W-1:0]        status_b,
  input  logic [COORD_WIDTH-1:0]     point_b_x,
  input  logic [COORD_WIDTH-1:0]     point_b_y,
  input  logic [COUNT_W-1:0]         point_count,
  input  logic [STATUS_W-1:0]        button_state,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DELTA_W-1:0]  delta_x,
  output logic signed [DELTA_W-1:0]  delta_y,
  output logic                       left_pressed,
  output logic                       right_pressed,
  output logic signed [WHEEL_W-1:0]  wheel_step
);

  localparam int Q_W = $bits(ctrl_t) + 3 * COORD_WIDTH;

  cfg_t                   cfg;
  logic                   cfg_we;
  reg_index_t             reg_idx;

  logic                   q_full;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_valid;
  logic [Q_W-1:0]         q_wdata;
  logic [Q_W-1:0]         q_rdata;

  ctrl_t                  f_ctrl;
  logic [COORD_WIDTH-1:0] f_mot_x;
  logic [COORD_WIDTH-1:0] f_mot_y;
  logic [COORD_WIDTH-1:0] f_a_y;
  ctrl_t                  b_ctrl;
  logic [COORD_WIDTH-1:0] b_mot_x;
  logic [COORD_WIDTH-1:0] b_mot_y;
  logic [COORD_WIDTH-1:0] b_a_y;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign reg_idx = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_limit <= MOVE_LIMIT_RST;
      cfg.button_zone_top <= BUTTON_ZONE_TOP_RST;
      cfg.x_limit <= X_LIMIT_RST;
      cfg.x_split <= X_SPLIT_RST;
      cfg.scroll_gap <= SCROLL_GAP_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MOVE_LIMIT: cfg.move_limit <= pwdata[REG_W-1:0];
        REG_BUTTON_ZONE_TOP: cfg.button_zone_top <= pwdata[REG_W-1:0];
        REG_X_LIMIT: cfg.x_limit <= pwdata[REG_W-1:0];
        REG_X_SPLIT: cfg.x_split <= pwdata[REG_W-1:0];
        REG_SCROLL_GAP: cfg.scroll_gap <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MOVE_LIMIT: prdata = DATA_W'(cfg.move_limit);
      REG_BUTTON_ZONE_TOP: prdata = DATA_W'(cfg.button_zone_top);
      REG_X_LIMIT: prdata = DATA_W'(cfg.x_limit);
      REG_X_SPLIT: prdata = DATA_W'(cfg.x_split);
      REG_SCROLL_GAP: prdata = DATA_W'(cfg.scroll_gap);
      default: prdata = '0;
    endcase
  end

  tprm_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status_a(status_a),
    .point_a_x(point_a_x),
    .point_a_y(point_a_y),
    .status_b(status_b),
    .point_b_x(point_b_x),
    .point_b_y(point_b_y),
    .point_count(point_count),
    .button_state(button_state),
    .cfg(cfg),
    .q_full(q_full),
    .push(q_push),
    .ctrl(f_ctrl),
    .mot_x(f_mot_x),
    .mot_y(f_mot_y),
    .a_y(f_a_y)
  );

  assign q_wdata = {f_ctrl, f_mot_x, f_mot_y, f_a_y};

  tprm_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wdata(q_wdata),
    .full(q_full),
    .pop(q_pop),
    .rd_valid(q_valid),
    .rdata(q_rdata)
  );

  assign {b_ctrl, b_mot_x, b_mot_y, b_a_y} = q_rdata;

  tprm_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .ctrl(b_ctrl),
    .mot_x(b_mot_x),
    .mot_y(b_mot_y),
    .a_y(b_a_y),
    .pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .delta_x(delta_x),
    .delta_y(delta_y),
    .left_pressed(left_pressed),
    .right_pressed(right_pressed),
    .wheel_step(wheel_step)
  );

endmodule
